// ===== sv/nga_pkg.sv =====
// Shared types, constants and state encodings for the 2D gravity acceleration unit.
`default_nettype none
package nga_pkg;

    localparam int NGA_MAX_BODIES = 64;
    localparam logic [23:0] GAIN_RESET = 24'd437407;

    // Bit widths of the pair datapath.
    localparam int DVD_W  = 113;  // g * m * |d| * 2^24
    localparam int DVS_W  = 99;   // S * floor(sqrt(S))
    localparam int NUM_W  = 89;   // g * m * |d|
    localparam int TERM_W = 58;   // signed pair term
    localparam int MAG_W  = 57;   // pair term magnitude
    localparam logic [MAG_W-1:0] TERM_LIMIT = MAG_W'(1) << 56;

    typedef struct packed {
        logic             done;
        logic             clip;
        logic [MAG_W-1:0] mag;
    } t_div_res;

    typedef struct packed {
        logic                     done;
        logic                     coin;
        logic                     clip;
        logic signed [TERM_W-1:0] tx;
        logic signed [TERM_W-1:0] ty;
    } t_pair_res;

    typedef enum logic [3:0] {
        P_IDLE, P_SQX, P_SQY, P_ROOT, P_DEN_LO, P_DEN_HI, P_GM,
        P_NX_LO, P_NX_HI, P_NY_LO, P_NY_HI, P_DIVGO, P_DIV, P_DONE
    } t_pair_state;

    typedef enum logic [2:0] {
        S_LOAD, S_RDI, S_LATI, S_JCHK, S_LATJ, S_PAIR, S_FIN, S_OUT
    } t_seq_state;

endpackage
`default_nettype wire

// ===== sv/nga_if.sv =====
// Handshake channels for body items and acceleration result items.
`default_nettype none
interface nga_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        mass;
    logic               last_body;

    modport source (output valid, pos_x, pos_y, mass, last_body, input ready);
    modport sink (input valid, pos_x, pos_y, mass, last_body, output ready);
endinterface

interface nga_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         body_index;
    logic signed [47:0] accel_x;
    logic signed [47:0] accel_y;
    logic               coincident;
    logic               saturated;
    logic               last_result;

    modport source (output valid, body_index, accel_x, accel_y, coincident, saturated,
                    last_result, input ready);
    modport sink (input valid, body_index, accel_x, accel_y, coincident, saturated,
                  last_result, output ready);
endinterface
`default_nettype wire

// ===== sv/nga_store.sv =====
// Body memory: position and mass per entry, one write and one registered read port.
`default_nettype none
module nga_store #(
    parameter int DEPTH = nga_pkg::NGA_MAX_BODIES
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [95:0]              i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [95:0]                   o_rdata
);
    logic [95:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/nga_div.sv =====
// Restoring divider, one quotient bit per cycle, with the pair term limit applied.
`default_nettype none
module nga_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [nga_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [nga_pkg::DVS_W-1:0] i_divisor,
    output nga_pkg::t_div_res              o_res
);
    import nga_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [6:0]       r_cnt;
    logic [DVD_W-1:0] r_num;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;
    logic             w_clip;

    assign w_trial = {r_rem, r_num[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});

    // Quotient above 2^56 is limited.
    assign w_clip = (|r_quo[DVD_W-1:MAG_W]) | (r_quo[MAG_W-1] & (|r_quo[MAG_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_num <= {r_num[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.clip = w_clip;
    assign o_res.mag  = w_clip ? TERM_LIMIT : r_quo[MAG_W-1:0];
endmodule
`default_nettype wire

// ===== sv/nga_pair.sv =====
// Pair interaction unit: shared 33x33 multiplier, serial square root, two dividers.
`default_nettype none
module nga_pair (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_xi,
    input  wire logic [31:0] i_yi,
    input  wire logic [31:0] i_xj,
    input  wire logic [31:0] i_yj,
    input  wire logic [31:0] i_mass,
    input  wire logic [23:0] i_gain,
    output nga_pkg::t_pair_res o_res
);
    import nga_pkg::*;

    t_pair_state r_state, n_state;

    logic [32:0]       r_ax, r_ay;
    logic              r_negx, r_negy;
    logic [31:0]       r_m;
    logic [65:0]       r_s;
    logic [65:0]       r_sq;
    logic [34:0]       r_rem;
    logic [32:0]       r_root;
    logic [5:0]        r_cnt;
    logic [DVS_W-1:0]  r_den;
    logic [55:0]       r_gm;
    logic [NUM_W-1:0]  r_nx, r_ny;
    logic              r_coin, r_clip;
    logic signed [TERM_W-1:0] r_tx, r_ty;

    logic [32:0] w_dx, w_dy;
    logic [32:0] w_ma, w_mb;
    logic [65:0] w_prod;
    logic [65:0] w_s_sum;
    logic [36:0] w_rem2;
    logic [36:0] w_rtrial;
    logic        w_rge;
    logic        w_div_go;
    t_div_res    w_resx, w_resy;

    assign w_dx = {i_xj[31], i_xj} - {i_xi[31], i_xi};
    assign w_dy = {i_yj[31], i_yj} - {i_yi[31], i_yi};

    always_comb begin
        w_ma = r_ax;
        w_mb = r_ax;
        case (r_state)
            P_SQY:    begin w_ma = r_ay;               w_mb = r_ay;          end
            P_DEN_LO: begin w_ma = r_s[32:0];          w_mb = r_root;        end
            P_DEN_HI: begin w_ma = r_s[65:33];         w_mb = r_root;        end
            P_GM:     begin w_ma = {9'b0, i_gain};     w_mb = {1'b0, r_m};   end
            P_NX_LO:  begin w_ma = {5'b0, r_gm[27:0]}; w_mb = r_ax;          end
            P_NX_HI:  begin w_ma = {5'b0, r_gm[55:28]}; w_mb = r_ax;         end
            P_NY_LO:  begin w_ma = {5'b0, r_gm[27:0]}; w_mb = r_ay;          end
            P_NY_HI:  begin w_ma = {5'b0, r_gm[55:28]}; w_mb = r_ay;         end
            default:  begin w_ma = r_ax;               w_mb = r_ax;          end
        endcase
    end

    assign w_prod   = w_ma * w_mb;
    assign w_s_sum  = r_s + w_prod;
    assign w_rem2   = {r_rem, r_sq[65:64]};
    assign w_rtrial = {2'b0, r_root, 2'b01};
    assign w_rge    = (w_rem2 >= w_rtrial);
    assign w_div_go = (r_state == P_DIVGO);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            P_IDLE:   if (i_start) n_state = P_SQX;
            P_SQX:    n_state = P_SQY;
            P_SQY:    n_state = (w_s_sum == '0) ? P_DONE : P_ROOT;
            P_ROOT:   if (r_cnt == 6'd0) n_state = P_DEN_LO;
            P_DEN_LO: n_state = P_DEN_HI;
            P_DEN_HI: n_state = P_GM;
            P_GM:     n_state = P_NX_LO;
            P_NX_LO:  n_state = P_NX_HI;
            P_NX_HI:  n_state = P_NY_LO;
            P_NY_LO:  n_state = P_NY_HI;
            P_NY_HI:  n_state = P_DIVGO;
            P_DIVGO:  n_state = P_DIV;
            P_DIV:    if (w_resx.done) n_state = P_DONE;
            P_DONE:   n_state = P_IDLE;
            default:  n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            P_IDLE: begin
                r_ax   <= w_dx[32] ? (33'd0 - w_dx) : w_dx;
                r_ay   <= w_dy[32] ? (33'd0 - w_dy) : w_dy;
                r_negx <= w_dx[32];
                r_negy <= w_dy[32];
                r_m    <= i_mass;
                r_coin <= 1'b0;
                r_clip <= 1'b0;
                r_tx   <= '0;
                r_ty   <= '0;
            end
            P_SQX: r_s <= w_prod;
            P_SQY: begin
                r_s    <= w_s_sum;
                r_sq   <= w_s_sum;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 6'd32;
                r_coin <= (w_s_sum == '0);
            end
            P_ROOT: begin
                r_rem  <= w_rge ? 35'(w_rem2 - w_rtrial) : w_rem2[34:0];
                r_root <= {r_root[31:0], w_rge};
                r_sq   <= {r_sq[63:0], 2'b00};
                r_cnt  <= r_cnt - 6'd1;
            end
            P_DEN_LO: r_den <= DVS_W'(w_prod);
            P_DEN_HI: r_den <= r_den + (DVS_W'(w_prod) << 33);
            P_GM:     r_gm  <= w_prod[55:0];
            P_NX_LO:  r_nx  <= NUM_W'(w_prod);
            P_NX_HI:  r_nx  <= r_nx + (NUM_W'(w_prod) << 28);
            P_NY_LO:  r_ny  <= NUM_W'(w_prod);
            P_NY_HI:  r_ny  <= r_ny + (NUM_W'(w_prod) << 28);
            P_DIV: begin
                if (w_resx.done) begin
                    r_tx   <= r_negx ? -$signed({1'b0, w_resx.mag})
                                     : $signed({1'b0, w_resx.mag});
                    r_ty   <= r_negy ? -$signed({1'b0, w_resy.mag})
                                     : $signed({1'b0, w_resy.mag});
                    r_clip <= w_resx.clip | w_resy.clip;
                end
            end
            default: ;
        endcase
    end

    nga_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend ({r_nx, 24'b0}),
        .i_divisor  (r_den),
        .o_res      (w_resx)
    );

    nga_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend ({r_ny, 24'b0}),
        .i_divisor  (r_den),
        .o_res      (w_resy)
    );

    assign o_res.done = (r_state == P_DONE);
    assign o_res.coin = r_coin;
    assign o_res.clip = r_clip;
    assign o_res.tx   = r_tx;
    assign o_res.ty   = r_ty;
endmodule
`default_nettype wire

// ===== sv/nbody_gravity_acceleration_unit.sv =====
// Top level: body loading, pair sequencing, acceleration sums and result register.
//
//  channel   direction  payload
//  i_body    in         pos_x, pos_y, mass, last_body
//  o_accel   out        body_index, accel_x, accel_y, coincident, saturated, last_result
//  i_cfg     in         gravity_gain (write enable and data)
//
// Loading accepts one body item per cycle. After the last body, each ordered pair of distinct
// bodies is worked by the 113-step bit-serial dividers and the 33-step square root in the
// pair unit; a pair at zero distance skips the square root and the division. Reset is
// synchronous; the body memory needs no clearing pass. A stalled result holds the sequencer
// until taken.
`default_nettype none
module nbody_gravity_acceleration_unit #(
    parameter int MAX_BODIES = nga_pkg::NGA_MAX_BODIES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nga_in_if.sink     i_body,
    nga_out_if.source  o_accel,
    input  wire logic  i_cfg_we,
    input  wire logic [23:0] i_cfg_data
);
    import nga_pkg::*;

    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam logic signed [63:0] ACC_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] ACC_MIN = -64'sd140737488355328;

    t_seq_state r_state, n_state;

    logic [23:0]        r_gain;
    logic [CW-1:0]      r_cnt, r_n, r_i, r_j;
    logic [31:0]        r_xi, r_yi;
    logic signed [63:0] r_sx, r_sy;
    logic               r_coin, r_clip;
    logic               r_o_valid;
    logic [5:0]         r_o_idx;
    logic [47:0]        r_o_ax, r_o_ay;
    logic               r_o_coin, r_o_sat, r_o_last;

    logic               w_in_acc, w_out_acc, w_store;
    logic [CW-1:0]      w_cnt_next;
    logic [AW-1:0]      w_raddr;
    logic [95:0]        w_rdata;
    t_pair_res          w_pair;
    logic [47:0]        w_fx, w_fy;
    logic               w_cx, w_cy;

    assign w_in_acc   = i_body.valid & i_body.ready;
    assign w_out_acc  = o_accel.valid & o_accel.ready;
    assign w_store    = w_in_acc & (r_cnt < CW'(MAX_BODIES));
    assign w_cnt_next = w_store ? (r_cnt + CW'(1)) : r_cnt;
    assign w_raddr    = (r_state == S_RDI) ? r_i[AW-1:0] : r_j[AW-1:0];

    nga_store #(.DEPTH(MAX_BODIES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_body.mass, i_body.pos_y, i_body.pos_x}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nga_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LATJ),
        .i_xi    (r_xi),
        .i_yi    (r_yi),
        .i_xj    (w_rdata[31:0]),
        .i_yj    (w_rdata[63:32]),
        .i_mass  (w_rdata[95:64]),
        .i_gain  (r_gain),
        .o_res   (w_pair)
    );

    // Final sums are clipped to the 48-bit signed range.
    always_comb begin
        w_cx = (r_sx > ACC_MAX) || (r_sx < ACC_MIN);
        w_cy = (r_sy > ACC_MAX) || (r_sy < ACC_MIN);
        w_fx = (r_sx > ACC_MAX) ? ACC_MAX[47:0] : ((r_sx < ACC_MIN) ? ACC_MIN[47:0] : r_sx[47:0]);
        w_fy = (r_sy > ACC_MAX) ? ACC_MAX[47:0] : ((r_sy < ACC_MIN) ? ACC_MIN[47:0] : r_sy[47:0]);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (w_in_acc && i_body.last_body) n_state = S_RDI;
            S_RDI:   n_state = S_LATI;
            S_LATI:  n_state = S_JCHK;
            S_JCHK: begin
                if (r_j == r_n) begin
                    n_state = S_FIN;
                end else if (r_j != r_i) begin
                    n_state = S_LATJ;
                end
            end
            S_LATJ:  n_state = S_PAIR;
            S_PAIR:  if (w_pair.done) n_state = S_JCHK;
            S_FIN:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_acc) begin
                    n_state = (r_i + CW'(1) == r_n) ? S_LOAD : S_RDI;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_gain    <= GAIN_RESET;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_gain <= i_cfg_data;
            end
            if (r_state == S_LOAD) begin
                r_cnt <= w_cnt_next;
            end else if (r_state == S_OUT && w_out_acc && r_i + CW'(1) == r_n) begin
                r_cnt <= '0;
            end
            if (r_state == S_FIN) begin
                r_o_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_n <= w_cnt_next;
                r_i <= '0;
            end
            S_LATI: begin
                r_xi   <= w_rdata[31:0];
                r_yi   <= w_rdata[63:32];
                r_j    <= '0;
                r_sx   <= '0;
                r_sy   <= '0;
                r_coin <= 1'b0;
                r_clip <= 1'b0;
            end
            S_JCHK: begin
                if (r_j != r_n && r_j == r_i) begin
                    r_j <= r_j + CW'(1);
                end
            end
            S_PAIR: begin
                if (w_pair.done) begin
                    r_j <= r_j + CW'(1);
                    if (w_pair.coin) begin
                        r_coin <= 1'b1;
                    end else begin
                        r_sx   <= r_sx + 64'(w_pair.tx);
                        r_sy   <= r_sy + 64'(w_pair.ty);
                        r_clip <= r_clip | w_pair.clip;
                    end
                end
            end
            S_FIN: begin
                r_o_idx  <= 6'(r_i);
                r_o_ax   <= w_fx;
                r_o_ay   <= w_fy;
                r_o_coin <= r_coin;
                r_o_sat  <= r_clip | w_cx | w_cy;
                r_o_last <= (r_i + CW'(1) == r_n);
            end
            S_OUT: begin
                if (w_out_acc) begin
                    r_i <= r_i + CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign i_body.ready        = (r_state == S_LOAD);
    assign o_accel.valid       = r_o_valid;
    assign o_accel.body_index  = r_o_idx;
    assign o_accel.accel_x     = r_o_ax;
    assign o_accel.accel_y     = r_o_ay;
    assign o_accel.coincident  = r_o_coin;
    assign o_accel.saturated   = r_o_sat;
    assign o_accel.last_result = r_o_last;

`ifndef SYNTHESIS
    a_out_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accel.valid |-> (r_state == S_OUT))
        else $error("result item valid outside the output state");
    a_no_load_during_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_body.ready |-> !o_accel.valid)
        else $error("body accepted while a result item is pending");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_BODIES))
        else $error("body count beyond store depth");
    a_pair_done_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pair.done |-> (r_state == S_PAIR))
        else $error("pair unit finished outside the pair state");
    a_skip_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LATJ) |-> (r_j != r_i))
        else $error("body paired with itself");
`endif
endmodule
`default_nettype wire

// ===== verif/nga_tb_if.sv =====
// Testbench side of the handshake channels; the interfaces themselves come from the RTL.
`timescale 1ns / 1ps

// ===== verif/nbody_gravity_acceleration_unit_tb.sv =====
// Testbench for the gravity unit: directed and random body sets checked against a pairwise-sum predictor.
`timescale 1ns / 1ps
`default_nettype none
module nbody_gravity_acceleration_unit_tb;
    import nga_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 47);

    typedef struct {
        logic [5:0]         idx;
        logic signed [47:0] ax;
        logic signed [47:0] ay;
        logic               coin;
        logic               sat;
        logic               last;
    } t_accel;

    class t_scoreboard;
        logic [23:0]        gain;
        logic signed [31:0] xs[$];
        logic signed [31:0] ys[$];
        logic [31:0]        ms[$];
        t_accel             expected_accels[$];
        int                 errors;
        int                 results_seen;
        int                 bodies_seen;
        int                 sets_done;

        function new();
            gain = GAIN_RESET;
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        function longint pair_term(logic [55:0] gm, logic [32:0] a, bit neg,
                                   logic [127:0] den, inout bit clip);
            logic [127:0] num;
            logic [127:0] q;
            num = 128'(gm) * (128'(a) << 24);
            q = num / den;
            if (q > (128'd1 << 56)) begin
                q = 128'd1 << 56;
                clip = 1;
            end
            return neg ? -longint'(q[56:0]) : longint'(q[56:0]);
        endfunction

        function logic [47:0] clamp(longint sum, inout bit clip);
            if (sum > ACC_HI) begin
                sum = ACC_HI;
                clip = 1;
            end
            if (sum < ACC_LO) begin
                sum = ACC_LO;
                clip = 1;
            end
            return sum[47:0];
        endfunction

        function void note_body(logic signed [31:0] x, logic signed [31:0] y,
                                logic [31:0] m, logic last);
            int n;
            longint sx, sy;
            bit coin, clip;
            logic signed [32:0] dx, dy;
            logic [32:0] ax, ay;
            logic [127:0] s, c, den;
            logic [63:0] root;
            logic [55:0] gm;
            t_accel r;
            bodies_seen++;
            // Bodies beyond the store size are dropped.
            if (xs.size() < NGA_MAX_BODIES) begin
                xs.push_back(x);
                ys.push_back(y);
                ms.push_back(m);
            end
            if (!last) return;
            n = xs.size();
            for (int i = 0; i < n; i++) begin
                sx = 0;
                sy = 0;
                coin = 0;
                clip = 0;
                for (int j = 0; j < n; j++) begin
                    if (j == i) continue;
                    dx = $signed({xs[j][31], xs[j]}) - $signed({xs[i][31], xs[i]});
                    dy = $signed({ys[j][31], ys[j]}) - $signed({ys[i][31], ys[i]});
                    ax = dx < 0 ? -dx : dx;
                    ay = dy < 0 ? -dy : dy;
                    s = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
                    if (s == 0) begin
                        coin = 1;
                        continue;
                    end
                    root = 0;
                    for (int b = 32; b >= 0; b--) begin
                        c = 128'(root | (64'd1 << b));
                        if (c * c <= s) root = c[63:0];
                    end
                    den = s * 128'(root);
                    gm = 56'(gain) * 56'(ms[j]);
                    sx += pair_term(gm, ax, dx < 0, den, clip);
                    sy += pair_term(gm, ay, dy < 0, den, clip);
                end
                r.idx = i[5:0];
                r.ax = clamp(sx, clip);
                r.ay = clamp(sy, clip);
                r.coin = coin;
                r.sat = clip;
                r.last = (i == n - 1);
                expected_accels.push_back(r);
            end
            xs.delete();
            ys.delete();
            ms.delete();
            sets_done++;
        endfunction

        task check(t_accel got);
            t_accel want;
            results_seen++;
            if (expected_accels.size() == 0) begin
                report("unexpected result, body_index", got.idx, -1);
                return;
            end
            want = expected_accels.pop_front();
            if (got.idx !== want.idx) report("body_index", got.idx, want.idx);
            if (got.ax !== want.ax) report("accel_x", got.ax, want.ax);
            if (got.ay !== want.ay) report("accel_y", got.ay, want.ay);
            if (got.coin !== want.coin) report("coincident", got.coin, want.coin);
            if (got.sat !== want.sat) report("saturated", got.sat, want.sat);
            if (got.last !== want.last) report("last_result", got.last, want.last);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [23:0] cfg_data;
    int          cycles;
    int          send_idle_pct;
    int          stall_pct;
    t_scoreboard sb;

    nga_in_if  body_if ();
    nga_out_if accel_if ();

    nbody_gravity_acceleration_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_body     (body_if),
        .o_accel    (accel_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        t_accel got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && body_if.valid && body_if.ready)
            sb.note_body(body_if.pos_x, body_if.pos_y, body_if.mass, body_if.last_body);
        if (i_rst_n && accel_if.valid && accel_if.ready) begin
            got.idx = accel_if.body_index;
            got.ax = accel_if.accel_x;
            got.ay = accel_if.accel_y;
            got.coin = accel_if.coincident;
            got.sat = accel_if.saturated;
            got.last = accel_if.last_result;
            sb.check(got);
        end
    end

    always @(negedge i_clk) begin
        accel_if.ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic send_body(logic signed [31:0] x, logic signed [31:0] y,
                             logic [31:0] m, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            body_if.valid = 1'b0;
            @(negedge i_clk);
        end
        body_if.valid = 1'b1;
        body_if.pos_x = x;
        body_if.pos_y = y;
        body_if.mass = m;
        body_if.last_body = last;
        do @(posedge i_clk); while (!body_if.ready);
        @(negedge i_clk);
    endtask

    // Waits until every expected result has been taken, then lets the block settle.
    task automatic drain();
        body_if.valid = 1'b0;
        while (sb.expected_accels.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_gain(logic [23:0] g);
        cfg_we = 1'b1;
        cfg_data = g;
        @(negedge i_clk);
        cfg_we = 1'b0;
        sb.gain = g;
    endtask

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(4095);
            default: return $urandom;
        endcase
    endfunction

    // Sends one set of n items; clustered sets keep distances short so sums grow.
    task automatic send_set(int n);
        logic signed [31:0] bx, by, x, y;
        bit clustered;
        clustered = $urandom_range(2) != 0;
        bx = $urandom;
        by = $urandom;
        x = bx;
        y = by;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0 && k > 0) begin
                // Repeat the previous position to get a zero-distance pair.
            end else if (clustered) begin
                x = bx + $signed(32'($urandom_range(65535)) - 32'sd32768);
                y = by + $signed(32'($urandom_range(65535)) - 32'sd32768);
            end else begin
                x = $urandom;
                y = $urandom;
            end
            send_body(x, y, pick_mass(), k == n - 1);
        end
    endtask

    initial begin
        int phase_items;
        logic [23:0] gains[4];
        int idle_pcts[4];
        int stall_pcts[4];
        sb = new();
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        body_if.valid = 1'b0;
        body_if.pos_x = '0;
        body_if.pos_y = '0;
        body_if.mass = '0;
        body_if.last_body = 1'b0;
        accel_if.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        gains = '{GAIN_RESET, 24'hFF_FFFF, 24'd0, 24'd1};
        idle_pcts = '{0, 83, 0, 37};
        stall_pcts = '{0, 0, 83, 37};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed sets under the reset gain: a lone body, extreme corners, coincident pair, unit distances.
        send_body(32'sd5, -32'sd7, 32'd100, 1'b1);
        send_body(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_body(32'sd4096, 32'sd4096, 32'd256, 1'b0);
        send_body(32'sd4096, 32'sd4096, 32'd256, 1'b0);
        send_body(-32'sd4096, 32'sd0, 32'd0, 1'b1);
        send_body(32'sd0, 32'sd0, 32'hFFFF_FFFF, 1'b0);
        send_body(32'sd1, 32'sd0, 32'hFFFF_FFFF, 1'b0);
        send_body(32'sd0, -32'sd1, 32'hFFFF_FFFF, 1'b1);
        // Full store: the two extra bodies are dropped, the last one still starts the sums.
        for (int k = 0; k < NGA_MAX_BODIES + 2; k++)
            send_body($signed(32'(k * 4096 + $urandom_range(4095))), $urandom,
                      pick_mass(), k == NGA_MAX_BODIES + 1);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_gain(p == 3 ? 24'($urandom) : gains[p]);
            send_idle_pct = idle_pcts[p];
            stall_pct = stall_pcts[p];
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
                send_set(n);
                phase_items += n;
                if ($urandom_range(7) == 0) drain();
            end
            drain();
            // Saturating set of three close bodies once the gain is at its top.
            if (p == 1) begin
                send_body(32'sd0, 32'sd0, 32'hFFFF_FFFF, 1'b0);
                send_body(32'sd1, 32'sd1, 32'hFFFF_FFFF, 1'b0);
                send_body(-32'sd1, 32'sd1, 32'hFFFF_FFFF, 1'b1);
                drain();
            end
        end

        $display("Covered %0d body items in %0d sets, %0d results checked, four gain settings.",
                 sb.bodies_seen, sb.sets_done, sb.results_seen);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
